// ===== src/jids_pkg.sv =====
// ----------------------------------------------------------------------------
// jids_pkg - shared types and tables for the JTAG IR/DR scan master
// Command codes, one-hot sequencer phases and the fixed TMS patterns.
// ----------------------------------------------------------------------------
package jids_pkg;

	// command codes carried in tuser
	typedef enum logic [1:0] {
		FUNC_ACCESS = 2'd0,
		FUNC_RESET  = 2'd1,
		FUNC_TICK   = 2'd2
	} func_t;

	// sequencer phases, one-hot
	typedef enum logic [7:0] {
		PH_IDLE     = 8'b0000_0001,
		PH_IR_PRE   = 8'b0000_0010,
		PH_IR_SHIFT = 8'b0000_0100,
		PH_IR_POST  = 8'b0000_1000,
		PH_DR_PRE   = 8'b0001_0000,
		PH_DR_SHIFT = 8'b0010_0000,
		PH_DR_POST  = 8'b0100_0000,
		PH_RESET    = 8'b1000_0000
	} phase_t;

	localparam int TDATA_IN_W  = 80;
	localparam int TDATA_OUT_W = 72;
	localparam int FIELD_DR_W  = 64;
	localparam int FIELD_IR_W  = 5;
	localparam int FIELD_LEN_W = 7;

	// TMS pattern of a fixed-pattern phase, bit 0 sent first
	function automatic logic pat_tms(phase_t ph, logic [2:0] idx);
		logic [7:0] pat;
		unique case (ph)
			PH_IR_PRE:  pat = 8'h03;
			PH_IR_POST: pat = 8'h06;
			PH_DR_PRE:  pat = 8'h01;
			PH_DR_POST: pat = 8'h01;
			PH_RESET:   pat = 8'h1F;
			default:    pat = 8'h00;
		endcase
		return pat[idx];
	endfunction

	// index of the last tick of a fixed-pattern phase
	function automatic logic [2:0] pat_last(phase_t ph);
		logic [2:0] last;
		unique case (ph)
			PH_IR_PRE:  last = 3'd3;
			PH_IR_POST: last = 3'd3;
			PH_DR_PRE:  last = 3'd2;
			PH_DR_POST: last = 3'd1;
			PH_RESET:   last = 3'd5;
			default:    last = 3'd0;
		endcase
		return last;
	endfunction

	// phase that follows a fixed-pattern phase
	function automatic phase_t pat_next(phase_t ph);
		phase_t nxt;
		unique case (ph)
			PH_IR_PRE:  nxt = PH_IR_SHIFT;
			PH_IR_POST: nxt = PH_DR_PRE;
			PH_DR_PRE:  nxt = PH_DR_SHIFT;
			default:    nxt = PH_IDLE;
		endcase
		return nxt;
	endfunction

endpackage

// ===== src/jtag_ir_dr_scan_master_unit.sv =====
// ----------------------------------------------------------------------------
// jtag_ir_dr_scan_master_unit - JTAG TAP master for IR/DR register access
// Sequences TMS/TDI one TCK at a time from Run-Test-Idle and captures TDO.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries commands. tuser selects the command: start an
//   access (IR value, DR value and DR length loaded from tdata), start a
//   soft reset (TMS 1,1,1,1,1,0), or one TCK tick (tdata carries the TDO
//   sampled in that cycle). Start commands produce no master transaction;
//   every tick produces exactly one master transaction with the TMS and TDI
//   levels for that TCK cycle. tlast marks the final tick of a sequence and
//   then tdata also holds the captured DR bits (bits at and above the DR
//   length are zero). Starts while a sequence runs are dropped.
//   A tick passes through the input register, then the result register, on
//   its way to the master side. Throughput is one transaction per cycle
//   while the receiver does not stall; the TMS/TDI of a tick follow from the
//   phase, bit counter and shift registers combinationally.
//   Reset leaves the sequencer idle with the TAP assumed in Run-Test-Idle
//   and both pipeline stages empty. When the receiver stalls, the result
//   register holds and the input register fills, then tready drops.
// ----------------------------------------------------------------------------
module jtag_ir_dr_scan_master_unit #(
	parameter int IR_WIDTH = 5,
	parameter int DR_MAX   = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave command stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tdata: ir_value[4:0], dr_value[68:5], dr_length[75:69], tdo[76], zero pad
	input  logic [jids_pkg::TDATA_IN_W-1:0]     s_tdata,
	// tuser: func[1:0]
	input  logic [1:0]                          s_tuser,
	// master tick stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata: tms[0], tdi[1], dr_captured[65:2], zero pad
	output logic [jids_pkg::TDATA_OUT_W-1:0]    m_tdata,
	// tlast: done_res
	output logic                                m_tlast
);

	// counter must reach the IR width, DR_MAX and the longest TMS pattern
	localparam int CNT_MAX = (IR_WIDTH > DR_MAX) ?
		((IR_WIDTH > 6) ? IR_WIDTH : 6) : ((DR_MAX > 6) ? DR_MAX : 6);
	localparam int CNT_W = $clog2(CNT_MAX + 1);

	// ---------------- input register ----------------
	logic                               v_s1;
	logic [1:0]                         func_s1;
	logic [jids_pkg::FIELD_IR_W-1:0]    ir_s1;
	logic [jids_pkg::FIELD_DR_W-1:0]    dr_s1;
	logic [jids_pkg::FIELD_LEN_W-1:0]   len_s1;
	logic                               tdo_s1;

	// ---------------- sequencer state ----------------
	jids_pkg::phase_t    phase_q;
	logic [CNT_W-1:0]    bit_count_q;
	logic [IR_WIDTH-1:0] ir_shift_q;
	logic [DR_MAX-1:0]   dr_shift_q;
	logic [CNT_W-1:0]    dr_len_q;
	logic [DR_MAX-1:0]   capture_q;

	// ---------------- result register ----------------
	logic                               m_tvalid_q;
	logic [jids_pkg::TDATA_OUT_W-1:0]   m_tdata_q;
	logic                               m_tlast_q;

	// next-state / result logic
	jids_pkg::phase_t    phase_d;
	logic [CNT_W-1:0]    bit_count_d;
	logic [IR_WIDTH-1:0] ir_shift_d;
	logic [DR_MAX-1:0]   dr_shift_d;
	logic [CNT_W-1:0]    dr_len_d;
	logic [DR_MAX-1:0]   capture_d;
	logic                has_result;
	logic                adv;
	logic                r_tms;
	logic                r_tdi;
	logic                r_done;
	logic [DR_MAX-1:0]   r_cap;
	logic [jids_pkg::FIELD_LEN_W-1:0] len_clamped;
	logic                busy;

	assign busy = (phase_q != jids_pkg::PH_IDLE);

	// only ticks produce a transaction; starts and func 3 just retire
	assign has_result = (func_s1 == jids_pkg::FUNC_TICK);
	assign adv        = v_s1 && (!has_result || !m_tvalid_q || m_tready);
	assign s_tready   = !v_s1 || adv;

	always_comb begin
		if (len_s1 == '0) begin
			len_clamped = jids_pkg::FIELD_LEN_W'(1);
		end else if (len_s1 > jids_pkg::FIELD_LEN_W'(DR_MAX)) begin
			len_clamped = jids_pkg::FIELD_LEN_W'(DR_MAX);
		end else begin
			len_clamped = len_s1;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		ir_shift_d  = ir_shift_q;
		dr_shift_d  = dr_shift_q;
		dr_len_d    = dr_len_q;
		capture_d   = capture_q;
		r_tms       = 1'b0;
		r_tdi       = 1'b0;
		r_done      = 1'b0;
		r_cap       = '0;

		unique case (func_s1)
			jids_pkg::FUNC_ACCESS: begin
				if (!busy) begin
					phase_d     = jids_pkg::PH_IR_PRE;
					bit_count_d = '0;
					capture_d   = '0;
					ir_shift_d  = IR_WIDTH'(ir_s1);
					dr_shift_d  = DR_MAX'(dr_s1);
					dr_len_d    = CNT_W'(len_clamped);
				end
			end
			jids_pkg::FUNC_RESET: begin
				if (!busy) begin
					phase_d     = jids_pkg::PH_RESET;
					bit_count_d = '0;
					capture_d   = '0;
				end
			end
			jids_pkg::FUNC_TICK: begin
				if (phase_q == jids_pkg::PH_IR_SHIFT) begin
					r_tdi       = ir_shift_q[0];
					ir_shift_d  = ir_shift_q >> 1;
					r_tms       = (bit_count_q == CNT_W'(IR_WIDTH - 1));
					bit_count_d = bit_count_q + CNT_W'(1);
					if (r_tms) begin
						phase_d     = jids_pkg::PH_IR_POST;
						bit_count_d = '0;
					end
				end else if (phase_q == jids_pkg::PH_DR_SHIFT) begin
					r_tdi      = dr_shift_q[0];
					dr_shift_d = dr_shift_q >> 1;
					// capture lane selected by the bit counter
					for (int j = 0; j < DR_MAX; j++) begin
						if (bit_count_q == CNT_W'(j)) begin
							capture_d[j] = capture_q[j] | tdo_s1;
						end
					end
					r_tms       = ((bit_count_q + CNT_W'(1)) == dr_len_q);
					bit_count_d = bit_count_q + CNT_W'(1);
					if (r_tms) begin
						phase_d     = jids_pkg::PH_DR_POST;
						bit_count_d = '0;
					end
				end else if (busy) begin
					r_tms       = jids_pkg::pat_tms(phase_q, bit_count_q[2:0]);
					bit_count_d = bit_count_q + CNT_W'(1);
					if (bit_count_q[2:0] == jids_pkg::pat_last(phase_q)) begin
						bit_count_d = '0;
						phase_d     = jids_pkg::pat_next(phase_q);
						if (phase_q == jids_pkg::PH_DR_POST ||
								phase_q == jids_pkg::PH_RESET) begin
							// capture is zero after a soft-reset start
							r_done = 1'b1;
							r_cap  = capture_q;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			m_tvalid_q  <= 1'b0;
			phase_q     <= jids_pkg::PH_IDLE;
			bit_count_q <= '0;
			ir_shift_q  <= '0;
			dr_shift_q  <= '0;
			dr_len_q    <= '0;
			capture_q   <= '0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv) begin
				phase_q     <= phase_d;
				bit_count_q <= bit_count_d;
				ir_shift_q  <= ir_shift_d;
				dr_shift_q  <= dr_shift_d;
				dr_len_q    <= dr_len_d;
				capture_q   <= capture_d;
			end
			if (adv && has_result) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			ir_s1   <= s_tdata[4:0];
			dr_s1   <= s_tdata[68:5];
			len_s1  <= s_tdata[75:69];
			tdo_s1  <= s_tdata[76];
		end
		if (adv && has_result) begin
			m_tdata_q <= {6'b0, jids_pkg::FIELD_DR_W'(r_cap), r_tdi, r_tms};
			m_tlast_q <= r_done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== tb/jtag_ir_dr_scan_master_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtag_ir_dr_scan_master_unit_test - self-checking bench for the scan master
// Drives access, soft-reset, tick and unused commands on the slave stream.
// An in-bench TAP sequencer model predicts every tick transaction, and each
// master transaction is checked field by field in arrival order. Both sides
// idle in random bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module jtag_ir_dr_scan_master_unit_test;

	localparam int          IR_W        = jids_pkg::FIELD_IR_W;
	localparam int          DR_W        = jids_pkg::FIELD_DR_W;
	localparam logic [1:0]  FUNC_UNUSED = 2'd3;   // no command, dropped by the block
	localparam int          HOLD_CYCLES = 60;     // long receiver hold-off
	localparam int          WATCHDOG    = 2000;   // cycles without any transaction
	localparam int          RAND_ITEMS  = 600;

	// one expected master transaction
	typedef struct packed {
		logic            tms;
		logic            tdi;
		logic            done;
		logic [DR_W-1:0] cap;
	} tick_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	// tdata: ir_value[4:0], dr_value[68:5], dr_length[75:69], tdo[76], zero pad
	logic [jids_pkg::TDATA_IN_W-1:0]  s_tdata;
	// tuser: func[1:0]
	logic [1:0]                       s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	// tdata: tms[0], tdi[1], dr_captured[65:2], zero pad
	logic [jids_pkg::TDATA_OUT_W-1:0] m_tdata;
	logic                             m_tlast;

	jtag_ir_dr_scan_master_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// sequencer model state, mirrors what the block should hold
	logic             tap_busy    = 1'b0;
	logic             tap_rst_seq = 1'b0;
	jids_pkg::phase_t tap_phase   = jids_pkg::PH_IDLE;
	logic [6:0]       tap_cnt     = '0;
	logic [IR_W-1:0]  ir_bits     = '0;
	logic [DR_W-1:0]  dr_bits     = '0;
	logic [6:0]       dr_len_q    = '0;
	logic [DR_W-1:0]  cap_bits    = '0;

	tick_t expected_ticks[$];

	// stimulus shaping
	bit sender_gaps = 1'b1;
	bit quiet_tail  = 1'b0;
	bit hold_req    = 1'b0;

	// bookkeeping
	int n_fail      = 0;
	int n_checked   = 0;
	int n_done      = 0;
	int n_accesses  = 0;
	int n_resets    = 0;
	int n_effective = 0;
	int stall_cycles = 0;

	// ------------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// TAP sequencer model: advance on one accepted command transaction and
	// queue the tick it produces, if any
	// ------------------------------------------------------------------------
	function automatic void step_tap_model(input logic [1:0] fn, input logic [IR_W-1:0] ir,
		input logic [DR_W-1:0] dr, input logic [6:0] len, input logic tdo);
		tick_t      r;
		logic [6:0] l;
		logic [7:0] pat;
		int         n;
		r = '0;
		if (fn == jids_pkg::FUNC_ACCESS || fn == jids_pkg::FUNC_RESET) begin
			if (tap_busy)
				return;     // start while busy is dropped
			n_effective++;
			tap_busy = 1'b1;
			tap_cnt  = '0;
			cap_bits = '0;
			if (fn == jids_pkg::FUNC_ACCESS) begin
				// zero length runs as one bit, long lengths clamp to the DR size
				l = len;
				if (l == 0)
					l = 7'd1;
				if (l > DR_W)
					l = 7'(DR_W);
				tap_rst_seq = 1'b0;
				tap_phase   = jids_pkg::PH_IR_PRE;
				ir_bits     = ir;
				dr_bits     = dr;
				dr_len_q    = l;
				n_accesses++;
			end else begin
				tap_rst_seq = 1'b1;
				tap_phase   = jids_pkg::PH_RESET;
				n_resets++;
			end
			return;
		end
		if (fn != jids_pkg::FUNC_TICK)
			return;
		n_effective++;
		// an idle tick leaves everything at zero, TAP parks in Run-Test-Idle
		if (tap_busy) begin
			unique case (tap_phase)
				jids_pkg::PH_IR_SHIFT: begin
					r.tdi   = ir_bits[0];
					ir_bits = ir_bits >> 1;
					r.tms   = (int'(tap_cnt) + 1 == IR_W);
					tap_cnt++;
					if (tap_cnt >= IR_W) begin
						tap_phase = jids_pkg::PH_IR_POST;
						tap_cnt   = '0;
					end
				end
				jids_pkg::PH_DR_SHIFT: begin
					r.tdi   = dr_bits[0];
					dr_bits = dr_bits >> 1;
					if (tap_cnt < DR_W)
						cap_bits[tap_cnt] = tdo;
					r.tms = (tap_cnt + 7'd1 == dr_len_q);
					tap_cnt++;
					if (tap_cnt >= dr_len_q) begin
						tap_phase = jids_pkg::PH_DR_POST;
						tap_cnt   = '0;
					end
				end
				default: begin
					// fixed TMS walks, first bit in bit 0
					unique case (tap_phase)
						jids_pkg::PH_IR_PRE:  begin pat = 8'b0000_0011; n = 4; end
						jids_pkg::PH_IR_POST: begin pat = 8'b0000_0110; n = 4; end
						jids_pkg::PH_DR_PRE:  begin pat = 8'b0000_0001; n = 3; end
						jids_pkg::PH_DR_POST: begin pat = 8'b0000_0001; n = 2; end
						jids_pkg::PH_RESET:   begin pat = 8'b0001_1111; n = 6; end
						default:              begin pat = 8'b0000_0000; n = 1; end
					endcase
					r.tms = pat[tap_cnt[2:0]];
					tap_cnt++;
					if (tap_cnt >= n) begin
						tap_cnt = '0;
						unique case (tap_phase)
							jids_pkg::PH_IR_PRE: tap_phase = jids_pkg::PH_IR_SHIFT;
							jids_pkg::PH_IR_POST: tap_phase = jids_pkg::PH_DR_PRE;
							jids_pkg::PH_DR_PRE: tap_phase = jids_pkg::PH_DR_SHIFT;
							default: begin
								r.done      = 1'b1;
								r.cap       = tap_rst_seq ? '0 : cap_bits;
								tap_busy    = 1'b0;
								tap_rst_seq = 1'b0;
								tap_phase   = jids_pkg::PH_IDLE;
							end
						endcase
					end
				end
			endcase
		end
		expected_ticks.push_back(r);
	endfunction

	// ------------------------------------------------------------------------
	// slave side: send one command, called and returning at a falling edge
	// ------------------------------------------------------------------------
	task automatic issue_cmd(input logic [1:0] fn, input logic [IR_W-1:0] ir,
		input logic [DR_W-1:0] dr, input logic [6:0] len, input logic tdo);
		if (sender_gaps && !quiet_tail && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {3'b000, tdo, len, dr, ir};
		do
			@(posedge clk);
		while (!s_tready);
		step_tap_model(fn, ir, dr, len, tdo);
		@(negedge clk);
	endtask

	function automatic logic [DR_W-1:0] rand_dr();
		return {$urandom, $urandom};
	endfunction

	// tick with random TDO and junk in the unused fields
	task automatic send_tick();
		issue_cmd(jids_pkg::FUNC_TICK, IR_W'($urandom), rand_dr(), 7'($urandom),
			1'($urandom));
	endtask

	// one command and the ticks that carry it to the end; noisy mixes in
	// starts that must be dropped and unused func codes
	task automatic run_seq(input logic [1:0] fn, input logic [IR_W-1:0] ir,
		input logic [DR_W-1:0] dr, input logic [6:0] len, input bit noisy);
		logic [1:0] junk;
		issue_cmd(fn, ir, dr, len, 1'($urandom));
		while (tap_busy) begin
			if (noisy && $urandom_range(0, 19) == 0) begin
				junk = 2'($urandom_range(0, 2));
				if (junk == jids_pkg::FUNC_TICK)
					junk = FUNC_UNUSED;
				issue_cmd(junk, IR_W'($urandom), rand_dr(), 7'($urandom), 1'($urandom));
			end else
				send_tick();
		end
	endtask

	// ------------------------------------------------------------------------
	// master side: random ready bursts, calm stretches, one long hold-off
	// ------------------------------------------------------------------------
	initial begin
		int calm_left;
		calm_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (quiet_tail || calm_left > 0) begin
				m_tready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
			end else if ($urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 49) == 0)
					calm_left = $urandom_range(20, 60);
			end
		end
	end

	// ------------------------------------------------------------------------
	// checker: every master transaction against the oldest expected tick
	// ------------------------------------------------------------------------
	task automatic flag_field(input string what, input logic [DR_W-1:0] want,
		input logic [DR_W-1:0] got);
		n_fail++;
		$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
	endtask

	always @(posedge clk) begin : check_ticks
		tick_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_ticks.size() == 0) begin
				n_fail++;
				$display("%0t: unexpected transaction, tdata 0x%0h tlast %0b",
					$time, m_tdata, m_tlast);
			end else begin
				want = expected_ticks.pop_front();
				n_checked++;
				if (m_tdata[0] !== want.tms)
					flag_field("tms", DR_W'(want.tms), DR_W'(m_tdata[0]));
				if (m_tdata[1] !== want.tdi)
					flag_field("tdi", DR_W'(want.tdi), DR_W'(m_tdata[1]));
				if (m_tlast !== want.done)
					flag_field("done", DR_W'(want.done), DR_W'(m_tlast));
				if (m_tdata[DR_W+1:2] !== want.cap)
					flag_field("dr_captured", want.cap, m_tdata[DR_W+1:2]);
				if (want.done)
					n_done++;
			end
		end
	end

	// watchdog: cycles in which neither side moves a transaction
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else if (stall_cycles >= WATCHDOG) begin
			$display("%0t: no transaction for %0d cycles, %0d ticks outstanding",
				$time, WATCHDOG, expected_ticks.size());
			$display("TB_ERROR");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// ticks with nothing running, plus an unused func code with all bits set
	task automatic test_idle_ticks();
		issue_cmd(jids_pkg::FUNC_TICK, '0, '0, '0, 1'b0);
		issue_cmd(jids_pkg::FUNC_TICK, '1, '1, '1, 1'b1);
		issue_cmd(FUNC_UNUSED, '1, '1, '1, 1'b1);
		issue_cmd(jids_pkg::FUNC_TICK, '0, '1, '0, 1'b1);
	endtask

	// soft reset walk; starts issued while it runs are dropped
	task automatic test_soft_reset();
		issue_cmd(jids_pkg::FUNC_RESET, '0, '0, '0, 1'b0);
		issue_cmd(jids_pkg::FUNC_ACCESS, '1, '1, 7'd64, 1'b1);
		send_tick();
		issue_cmd(jids_pkg::FUNC_RESET, '0, '0, '0, 1'b0);
		while (tap_busy)
			send_tick();
	endtask

	// field extremes: IR all ones / zero, shortest, zero, full and oversize DR
	task automatic test_access_extremes();
		run_seq(jids_pkg::FUNC_ACCESS, '1, '1, 7'd1, 1'b0);
		run_seq(jids_pkg::FUNC_ACCESS, '0, '0, 7'd0, 1'b0);
		run_seq(jids_pkg::FUNC_ACCESS, 5'h15, 64'hA5A5_5A5A_F00F_0FF0, 7'd64, 1'b0);
		run_seq(jids_pkg::FUNC_ACCESS, 5'h0A, rand_dr(), 7'd127, 1'b0);
	endtask

	// receiver stops for a long stretch while ticks keep coming
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		hold_req    = 1'b1;
		run_seq(jids_pkg::FUNC_ACCESS, IR_W'($urandom), rand_dr(), 7'd40, 1'b0);
		sender_gaps = 1'b1;
	endtask

	// mostly well-formed accesses and resets with random content, some noise
	task automatic test_random();
		int         r;
		int         pick;
		logic [6:0] len;
		while (n_effective < RAND_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					len = 7'($urandom_range(1, 16));
				else if (pick < 8)
					len = 7'($urandom_range(17, 63));
				else if (pick < 9)
					len = 7'd64;
				else
					len = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
				run_seq(jids_pkg::FUNC_ACCESS, IR_W'($urandom), rand_dr(), len,
					$urandom_range(0, 3) == 0);
			end else if (r < 88)
				run_seq(jids_pkg::FUNC_RESET, IR_W'($urandom), rand_dr(), 7'($urandom),
					$urandom_range(0, 3) == 0);
			else if (r < 95)
				repeat ($urandom_range(1, 4))
					send_tick();
			else
				issue_cmd(FUNC_UNUSED, IR_W'($urandom), rand_dr(), 7'($urandom),
					1'($urandom));
		end
	endtask

	// closing stretch at full rate on both sides
	task automatic test_full_rate();
		quiet_tail = 1'b1;
		run_seq(jids_pkg::FUNC_ACCESS, IR_W'($urandom), rand_dr(),
			7'($urandom_range(1, 64)), 1'b0);
		run_seq(jids_pkg::FUNC_RESET, '0, '0, '0, 1'b0);
		run_seq(jids_pkg::FUNC_ACCESS, IR_W'($urandom), rand_dr(),
			7'($urandom_range(1, 8)), 1'b0);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = '0;
		s_tdata  = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_ticks();
		test_soft_reset();
		test_access_extremes();
		test_backpressure();
		test_random();
		test_full_rate();

		s_tvalid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		// pipeline is two deep; let any stray transaction show up
		repeat (10) @(posedge clk);

		$display("covered %0d accesses and %0d soft resets, %0d commands acted on",
			n_accesses, n_resets, n_effective);
		$display("checked %0d tick transactions, %0d sequence ends, %0d mismatches",
			n_checked, n_done, n_fail);
		if (n_fail == 0 && expected_ticks.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== jtag_ir_dr_scan_master_unit.f =====
src/jids_pkg.sv
src/jtag_ir_dr_scan_master_unit.sv
tb/jtag_ir_dr_scan_master_unit_test.sv
